>>> src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, types and helpers for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY  = 16;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int VAL_W     = 32;
  localparam int CMP_W     = 5;
  localparam int COUNT_MAX = 31;
  localparam int SAT_W     = (CNT_W > CMP_W) ? CNT_W : CMP_W;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REM,
    ST_WALK,
    ST_PLACE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              now_empty;
    logic              insert_dropped;
    logic [CMP_W-1:0]  compare_count;
    logic              removed_valid;
    logic [VAL_W-1:0]  removed_value;
  } res_t;

  // head + offset, wrapped into the circular store
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] head,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= (IDX_W + 1)'(CAPACITY)) begin
      sum = sum - (IDX_W + 1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [CMP_W-1:0] sat_cmp(input logic [CNT_W-1:0] c);
    logic [SAT_W-1:0] ext;
    ext = SAT_W'(c);
    if (ext > SAT_W'(COUNT_MAX)) begin
      ext = SAT_W'(COUNT_MAX);
    end
    return ext[CMP_W-1:0];
  endfunction

endpackage

>>> src/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer and entry store. Entries sit in a circular buffer memory; an
// insert walks from the tail down, moving larger-or-equal entries up one slot.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_mode,
  input  logic signed [spq_pkg::VAL_W-1:0] in_value,
  input  logic                         out_free,
  output logic                         res_valid,
  output spq_pkg::res_t                res
);

  spq_pkg::state_t state_r, state_nxt;

  logic signed [spq_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [spq_pkg::IDX_W-1:0] head_r, head_nxt;
  logic [spq_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [spq_pkg::IDX_W-1:0] k_r, k_nxt;
  spq_pkg::res_t res_r, res_nxt;

  logic [spq_pkg::VAL_W-1:0] mem [spq_pkg::CAPACITY];
  logic [spq_pkg::VAL_W-1:0] rd_q;
  logic                      we;
  logic [spq_pkg::IDX_W-1:0] wa;
  logic [spq_pkg::VAL_W-1:0] wd;
  logic [spq_pkg::IDX_W-1:0] ra;

  logic                      accept;
  logic                      full;
  logic                      empty;
  logic [spq_pkg::CNT_W-1:0] cnt_m1;
  logic [spq_pkg::CNT_W-1:0] cnt_p1;
  logic [spq_pkg::IDX_W-1:0] k_p1;
  logic                      rd_less;
  logic                      at_tail;

  assign accept   = in_valid && in_ready;
  assign full     = (count_r == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
  assign empty    = (count_r == '0);
  assign cnt_m1   = count_r - spq_pkg::CNT_W'(1);
  assign cnt_p1   = count_r + spq_pkg::CNT_W'(1);
  assign k_p1     = k_r + spq_pkg::IDX_W'(1);
  assign rd_less  = ($signed(rd_q) < val_r);
  assign at_tail  = (spq_pkg::CNT_W'(k_r) == cnt_m1);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spq_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_mode == spq_pkg::MODE_REMOVE) begin
            state_nxt = empty ? spq_pkg::ST_DONE : spq_pkg::ST_REM;
          end else if (full || empty) begin
            state_nxt = spq_pkg::ST_DONE;
          end else begin
            state_nxt = spq_pkg::ST_WALK;
          end
        end
      end
      spq_pkg::ST_REM:   state_nxt = spq_pkg::ST_DONE;
      spq_pkg::ST_WALK: begin
        if (rd_less) begin
          state_nxt = spq_pkg::ST_DONE;
        end else if (k_r == '0) begin
          state_nxt = spq_pkg::ST_PLACE;
        end
      end
      spq_pkg::ST_PLACE: state_nxt = spq_pkg::ST_DONE;
      spq_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = spq_pkg::ST_IDLE;
        end
      end
      default:  state_nxt = spq_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready  = (state_r == spq_pkg::ST_IDLE);
    res_valid = (state_r == spq_pkg::ST_DONE);
    res       = res_r;
    val_nxt   = val_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    k_nxt     = k_r;
    res_nxt   = res_r;
    we        = 1'b0;
    wa        = head_r;
    wd        = val_r;
    ra        = head_r;
    case (state_r)
      spq_pkg::ST_IDLE: begin
        if (accept) begin
          val_nxt = in_value;
          res_nxt = '0;
          if (in_mode == spq_pkg::MODE_REMOVE) begin
            res_nxt.now_empty = empty;
          end else if (full) begin
            res_nxt.insert_dropped = 1'b1;
          end else if (empty) begin
            we        = 1'b1;
            wa        = head_r;
            wd        = in_value;
            count_nxt = cnt_p1;
          end else begin
            k_nxt = cnt_m1[spq_pkg::IDX_W-1:0];
            ra    = spq_pkg::wrap_add(head_r, cnt_m1[spq_pkg::IDX_W-1:0]);
          end
        end
      end
      spq_pkg::ST_REM: begin
        res_nxt.removed_value = rd_q;
        res_nxt.removed_valid = 1'b1;
        res_nxt.now_empty     = (count_r == spq_pkg::CNT_W'(1));
        head_nxt              = spq_pkg::wrap_add(head_r, spq_pkg::IDX_W'(1));
        count_nxt             = cnt_m1;
      end
      spq_pkg::ST_WALK: begin
        we = 1'b1;
        wa = spq_pkg::wrap_add(head_r, k_p1);
        if (rd_less) begin
          wd                    = val_r;
          count_nxt             = cnt_p1;
          // no stopping compare when the value lands past the tail
          res_nxt.compare_count = spq_pkg::sat_cmp(spq_pkg::CNT_W'(k_r)
                                    + (at_tail ? spq_pkg::CNT_W'(1)
                                               : spq_pkg::CNT_W'(2)));
        end else begin
          wd = rd_q;
          if (k_r != '0) begin
            k_nxt = k_r - spq_pkg::IDX_W'(1);
            ra    = spq_pkg::wrap_add(head_r, k_r - spq_pkg::IDX_W'(1));
          end
        end
      end
      spq_pkg::ST_PLACE: begin
        we                    = 1'b1;
        wa                    = head_r;
        wd                    = val_r;
        count_nxt             = cnt_p1;
        res_nxt.compare_count = spq_pkg::sat_cmp(spq_pkg::CNT_W'(1));
      end
      spq_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    k_r   <= k_nxt;
    res_r <= res_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= spq_pkg::CNT_W'(spq_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spq_pkg::ST_WALK) |->
      (count_r != '0) && (spq_pkg::CNT_W'(k_r) < count_r))
    else $error("walk with no stored entry");

  a_rem_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spq_pkg::ST_REM) |=> (count_r == $past(cnt_m1)))
    else $error("remove did not decrement count");

  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spq_pkg::ST_DONE && out_free) |=> (state_r == spq_pkg::ST_IDLE))
    else $error("result handoff did not return to idle");

endmodule

>>> src/spq_obuf.sv
// ----------------------------------------------------------------------------
// spq_obuf
// Output register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module spq_obuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ld_valid,
  input  spq_pkg::res_t ld_res,
  output logic          free,
  output logic          out_valid,
  input  logic          out_ready,
  output spq_pkg::res_t out_res
);

  logic          valid_r, valid_nxt;
  spq_pkg::res_t res_r, res_nxt;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (free) begin
      valid_nxt = ld_valid;
      if (ld_valid) begin
        res_nxt = ld_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

>>> src/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Priority queue of signed 32-bit values kept in ascending order.
// ----------------------------------------------------------------------------
// Channel  Dir  Signals                       Transaction
// in       in   in_tvalid/tready/tdata/tuser  tuser: mode, tdata: value
// out      out  out_tvalid/tready/tdata       one result per input
//
// Remove from a non-empty queue reads the head entry in the REM state.
// Remove from an empty queue, insert into an empty or full queue: no memory walk.
// Insert otherwise walks down over the stored entries not smaller than the value;
// the walk moves one entry per cycle through the single-port-pair memory.
// Reset clears the count and head pointer; store contents are not cleared.
// A stalled output holds the finished result; the next transaction is taken
// while it waits, and its own result waits for the output register to free.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] removed_value, [32] removed_valid,
                                  // [37:33] compare_count, [38] insert_dropped,
                                  // [39] now_empty
);

  logic          res_valid;
  logic          out_free;
  spq_pkg::res_t res;
  spq_pkg::res_t out_res;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .in_value  ($signed(in_tdata)),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  spq_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_valid  (res_valid),
    .ld_res    (res),
    .free      (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res;

endmodule

>>> sim/sorted_priority_queue_top_tb.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_tb
// Self-checking bench for the sorted priority queue. Drives insert and remove
// transactions, predicts each result from a local sorted copy of the queue or a
// table row, and compares every returned result field by field, under random back-pressure.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 400;

  typedef struct packed {
    logic          mode;
    logic [31:0]   value;
    logic          typed;
    spq_pkg::res_t want;
  } dir_row_t;

  // want: {now_empty, insert_dropped, compare_count, removed_valid, removed_value}
  localparam dir_row_t DIR_TABLE [24] = '{
    '{spq_pkg::MODE_REMOVE, 32'h0000_0000, 1'b1, '{1'b1, 1'b0, 5'd0, 1'b0, 32'h0}},
    '{spq_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 5'd0, 1'b0, 32'h0}},
    '{spq_pkg::MODE_INSERT, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 5'd0, 1'b0, 32'h0}},
    '{spq_pkg::MODE_REMOVE, 32'h0000_0000, 1'b1, '{1'b1, 1'b0, 5'd0, 1'b1, 32'h0}},
    '{spq_pkg::MODE_INSERT, 32'h7FFF_FFFF, 1'b1, '{1'b0, 1'b0, 5'd0, 1'b0, 32'h0}},
    '{spq_pkg::MODE_INSERT, 32'h8000_0000, 1'b1, '{1'b0, 1'b0, 5'd1, 1'b0, 32'h0}},
    '{spq_pkg::MODE_INSERT, 32'h7FFF_FFFF, 1'b0, '0},
    '{spq_pkg::MODE_INSERT, 32'h0000_0005, 1'b0, '0},
    '{spq_pkg::MODE_INSERT, 32'h0000_0005, 1'b0, '0},
    '{spq_pkg::MODE_INSERT, 32'hFFFF_FFFF, 1'b0, '0},
    '{spq_pkg::MODE_INSERT, 32'h0000_0000, 1'b0, '0},
    '{spq_pkg::MODE_INSERT, 32'h0000_0064, 1'b0, '0},
    '{spq_pkg::MODE_INSERT, 32'hFFFF_FF9C, 1'b0, '0},
    '{spq_pkg::MODE_INSERT, 32'h8000_0000, 1'b0, '0},
    '{spq_pkg::MODE_INSERT, 32'h0000_0003, 1'b0, '0},
    '{spq_pkg::MODE_INSERT, 32'h0000_0003, 1'b0, '0},
    '{spq_pkg::MODE_INSERT, 32'h0000_0001, 1'b0, '0},
    '{spq_pkg::MODE_INSERT, 32'h0000_0002, 1'b0, '0},
    '{spq_pkg::MODE_INSERT, 32'h7FFF_FFFE, 1'b0, '0},
    '{spq_pkg::MODE_INSERT, 32'h8000_0001, 1'b0, '0},
    '{spq_pkg::MODE_INSERT, 32'h0000_0000, 1'b1, '{1'b0, 1'b1, 5'd0, 1'b0, 32'h0}},
    '{spq_pkg::MODE_REMOVE, 32'h1234_5678, 1'b1,
      '{1'b0, 1'b0, 5'd0, 1'b1, 32'h8000_0000}},
    '{spq_pkg::MODE_INSERT, 32'h7FFF_FFFF, 1'b0, '0},
    '{spq_pkg::MODE_INSERT, 32'h8000_0000, 1'b1, '{1'b0, 1'b1, 5'd0, 1'b0, 32'h0}}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  logic [31:0]   held_values[$];
  spq_pkg::res_t pending_results[$];
  int            err_count;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            hold_left;
  int            quiet_cycles;

  sorted_priority_queue_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // sorted-list behavior: new value goes ahead of equal entries
  function automatic spq_pkg::res_t queue_step(logic mode, logic [31:0] value);
    spq_pkg::res_t r;
    int            pos;
    int            cmps;
    r = '0;
    if (mode == spq_pkg::MODE_INSERT) begin
      if (held_values.size() >= spq_pkg::CAPACITY) begin
        r.insert_dropped = 1'b1;
      end else begin
        pos = 0;
        while (pos < held_values.size() && $signed(held_values[pos]) < $signed(value))
          pos++;
        cmps = pos + ((pos < held_values.size()) ? 1 : 0);
        if (cmps > spq_pkg::COUNT_MAX) cmps = spq_pkg::COUNT_MAX;
        r.compare_count = spq_pkg::CMP_W'(cmps);
        held_values.insert(pos, value);
      end
    end else if (held_values.size() > 0) begin
      r.removed_value = held_values.pop_front();
      r.removed_valid = 1'b1;
    end
    r.now_empty = (held_values.size() == 0);
    return r;
  endfunction

  task automatic send_item(logic mode, logic [31:0] value, logic typed,
                           spq_pkg::res_t want);
    spq_pkg::res_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = value;
    do @(posedge clk); while (!in_tready);
    predicted = queue_step(mode, value);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_idle(int send_pct, int recv_pct);
    @(negedge clk);
    in_tvalid = 1'b0;
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    int          k;
    k = $urandom_range(9);
    case (k)
      5, 6: v = 32'($urandom_range(15)) - 32'd8;
      7: v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      8: begin
        if (held_values.size() > 0)
          v = held_values[$urandom_range(held_values.size() - 1)]
              + 32'($urandom_range(2)) - 32'd1;
        else
          v = $urandom;
      end
      9: v = $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // bursts weighted toward inserts, toward removes, or mixed
  task automatic run_random(int n_items);
    int   sent;
    int   burst_len;
    int   insert_pct;
    logic mode;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(3))
        0: insert_pct = 85;
        1: insert_pct = 15;
        default: insert_pct = 50;
      endcase
      burst_len = $urandom_range(4, 40);
      repeat (burst_len) begin
        mode = ($urandom_range(99) < insert_pct) ? spq_pkg::MODE_INSERT
                                                 : spq_pkg::MODE_REMOVE;
        send_item(mode, pick_value(), 1'b0, '0);
        sent++;
      end
    end
  endtask

  task automatic check_result(spq_pkg::res_t got);
    spq_pkg::res_t want;
    if (pending_results.size() == 0) begin
      report_error($sformatf("result %h with nothing expected", got));
    end else begin
      want = pending_results.pop_front();
      if (got.removed_value !== want.removed_value)
        report_error($sformatf("removed_value %h, expected %h",
                               got.removed_value, want.removed_value));
      if (got.removed_valid !== want.removed_valid)
        report_error($sformatf("removed_valid %b, expected %b",
                               got.removed_valid, want.removed_valid));
      if (got.compare_count !== want.compare_count)
        report_error($sformatf("compare_count %0d, expected %0d",
                               got.compare_count, want.compare_count));
      if (got.insert_dropped !== want.insert_dropped)
        report_error($sformatf("insert_dropped %b, expected %b",
                               got.insert_dropped, want.insert_dropped));
      if (got.now_empty !== want.now_empty)
        report_error($sformatf("now_empty %b, expected %b",
                               got.now_empty, want.now_empty));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result(spq_pkg::res_t'(out_tdata));
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = 1'b0;
    err_count     = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 0;
    quiet_cycles  = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_idle(20, 74);
    foreach (DIR_TABLE[i])
      send_item(DIR_TABLE[i].mode, DIR_TABLE[i].value, DIR_TABLE[i].typed,
                DIR_TABLE[i].want);
    run_random(650);
    wait_drained();

    set_idle(74, 20);
    run_random(650);

    set_idle(0, 0);
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    repeat (40) send_item(spq_pkg::MODE_INSERT, pick_value(), 1'b0, '0);
    run_random(600);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sorted_priority_queue_top.f
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_obuf.sv
src/sorted_priority_queue_top.sv
sim/sorted_priority_queue_top_tb.sv
